[rtl/min_heap_priority_queue_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the min-heap priority queue
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define MHPQ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: label");
`define MHPQ_ASSERT_NEVER(label, clk, rst_n, cond) \
  `MHPQ_ASSERT(label, clk, rst_n, !(cond))
`else
`define MHPQ_ASSERT(label, clk, rst_n, prop)
`define MHPQ_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

[rtl/mhpq_pkg.sv]
// ----------------------------------------------------------------------------
// Min-heap priority queue package
// Shared widths, codes and control types of the priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

[rtl/mhpq_in_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Carries one push or pop request per transfer.
// ----------------------------------------------------------------------------
interface mhpq_in_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic signed [mhpq_pkg::DATA_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

[rtl/mhpq_out_if.sv]
// ----------------------------------------------------------------------------
// Response channel
// Carries the status, removed minimum and entry count of one request.
// ----------------------------------------------------------------------------
interface mhpq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [mhpq_pkg::STATUS_W-1:0]        status;
  logic signed [mhpq_pkg::DATA_W-1:0]   popped;
  logic [mhpq_pkg::OCC_W-1:0]           occupancy;

  modport source (output valid, output status, output popped, output occupancy, input ready);
  modport sink (input valid, input status, input popped, input occupancy, output ready);
endinterface

[rtl/min_heap_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// Min-heap priority queue
// Each response is registered and is valid in the cycle after its transfer.
// One request per cycle unless rsp_o stalls; all cells update together.
// Reset clears the entry count and the response valid flag; entries need none.
// ----------------------------------------------------------------------------
`include "min_heap_priority_queue_top_assert.svh"

module min_heap_priority_queue_top #(
  parameter int unsigned Capacity = mhpq_pkg::CAPACITY
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mhpq_in_if.sink           req_i,
  mhpq_out_if.source        rsp_o
);

  localparam int unsigned CntW = ($clog2(Capacity + 1) > mhpq_pkg::OCC_W) ?
                                 $clog2(Capacity + 1) : mhpq_pkg::OCC_W;

  logic [CntW-1:0]                    count_q;
  logic [CntW-1:0]                    count_d;
  logic                               accept;
  logic                               is_pop;
  logic                               push_ok;
  logic                               pop_ok;
  mhpq_pkg::cell_ctrl_t               ctrl;

  logic                               cell_valid [Capacity];
  logic                               cell_lt    [Capacity];
  logic signed [mhpq_pkg::DATA_W-1:0] cell_value [Capacity];

  logic                               rsp_valid_q;
  logic [mhpq_pkg::STATUS_W-1:0]      status_q;
  logic [mhpq_pkg::STATUS_W-1:0]      status_d;
  logic signed [mhpq_pkg::DATA_W-1:0] popped_q;
  logic signed [mhpq_pkg::DATA_W-1:0] popped_d;
  logic [mhpq_pkg::OCC_W-1:0]         occ_q;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign is_pop      = (req_i.op == mhpq_pkg::OP_POP);
  assign push_ok     = accept && !is_pop && (count_q != CntW'(Capacity));
  assign pop_ok      = accept && is_pop && (count_q != '0);
  assign ctrl.push   = push_ok;
  assign ctrl.pop    = pop_ok;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic                               prev_lt;
    logic signed [mhpq_pkg::DATA_W-1:0] prev_value;
    logic signed [mhpq_pkg::DATA_W-1:0] next_value;

    assign cell_valid[i] = (count_q > CntW'(i));

    if (i == 0) begin : g_first
      assign prev_lt    = 1'b0;
      assign prev_value = req_i.value;
    end else begin : g_inner
      assign prev_lt    = cell_lt[i-1];
      assign prev_value = cell_value[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign next_value = cell_value[i];
    end else begin : g_more
      assign next_value = cell_value[i+1];
    end

    mhpq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (cell_valid[i]),
      .new_value_i  (req_i.value),
      .prev_lt_i    (prev_lt),
      .prev_value_i (prev_value),
      .next_value_i (next_value),
      .lt_o         (cell_lt[i]),
      .value_o      (cell_value[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = mhpq_pkg::ST_OK;
    popped_d = '0;
    priority if (push_ok) begin
      count_d = count_q + CntW'(1);
    end else if (pop_ok) begin
      count_d  = count_q - CntW'(1);
      popped_d = cell_value[0];
    end else if (is_pop) begin
      status_d = mhpq_pkg::ST_EMPTY;
    end else begin
      status_d = mhpq_pkg::ST_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      popped_q <= popped_d;
      occ_q    <= count_d[mhpq_pkg::OCC_W-1:0];
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.popped    = popped_q;
  assign rsp_o.occupancy = occ_q;

  `MHPQ_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CntW'(Capacity))
  `MHPQ_ASSERT(a_fail_pops_zero, clk_i, rst_ni, (rsp_valid_q && (status_q != mhpq_pkg::ST_OK)) |-> (popped_q == '0))
  `MHPQ_ASSERT(a_head_sorted, clk_i, rst_ni, (count_q >= CntW'(2)) |-> (cell_value[0] <= cell_value[1]))
  `MHPQ_ASSERT(a_pop_count, clk_i, rst_ni, pop_ok |=> (count_q == $past(count_q) - CntW'(1)))

endmodule

[rtl/mhpq_cell.sv]
// ----------------------------------------------------------------------------
// Priority queue cell
// Holds one entry of the sorted chain and trades it with its neighbors.
// ----------------------------------------------------------------------------
module mhpq_cell (
  input  logic                               clk_i,
  input  mhpq_pkg::cell_ctrl_t               ctrl_i,
  input  logic                               valid_i,
  input  logic signed [mhpq_pkg::DATA_W-1:0] new_value_i,
  input  logic                               prev_lt_i,
  input  logic signed [mhpq_pkg::DATA_W-1:0] prev_value_i,
  input  logic signed [mhpq_pkg::DATA_W-1:0] next_value_i,
  output logic                               lt_o,
  output logic signed [mhpq_pkg::DATA_W-1:0] value_o
);

  logic signed [mhpq_pkg::DATA_W-1:0] value_q;
  logic signed [mhpq_pkg::DATA_W-1:0] value_d;

  // An empty cell behaves as if it held plus infinity.
  assign lt_o = !valid_i || (new_value_i < value_q);

  always_comb begin
    value_d = value_q;
    priority if (ctrl_i.pop) begin
      value_d = next_value_i;
    end else if (ctrl_i.push && lt_o) begin
      value_d = prev_lt_i ? prev_value_i : new_value_i;
    end else begin
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
